// ----- rtl/core/dop_pkg.sv -----
`timescale 1ns / 1ps
package dop_pkg;

  localparam int NumSlots = 7;
  localparam int SlotW = 3;

  localparam logic [SlotW-1:0] NO_SLOT = 3'd7;

  localparam logic [1:0] PH_TYPE  = 2'd0;
  localparam logic [1:0] PH_LEN   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_LEN = 2'd1;
  localparam logic [1:0] ST_BAD_MSG = 2'd2;
  localparam logic [1:0] ST_NO_END  = 2'd3;

  localparam logic [7:0] OPT_PAD       = 8'd0;
  localparam logic [7:0] OPT_MASK      = 8'd1;
  localparam logic [7:0] OPT_GATEWAY   = 8'd3;
  localparam logic [7:0] OPT_BCAST     = 8'd28;
  localparam logic [7:0] OPT_LEASE     = 8'd51;
  localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
  localparam logic [7:0] OPT_SERVER    = 8'd54;
  localparam logic [7:0] OPT_RENEWAL   = 8'd58;
  localparam logic [7:0] OPT_REBINDING = 8'd59;
  localparam logic [7:0] OPT_END       = 8'd255;

  localparam logic [7:0] MSG_OFFER = 8'd2;
  localparam logic [7:0] MSG_ACK   = 8'd5;

  localparam logic [SlotW-1:0] SLOT_BCAST = 3'd2;

  typedef struct packed {
    logic [7:0]  option_byte;
    logic        first;
    logic        last;
    logic [31:0] your_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] host_address;
    logic [31:0] subnet_mask;
    logic [31:0] router_address;
    logic [31:0] broadcast_address;
    logic [31:0] server_id;
    logic [31:0] lease_seconds;
    logic [31:0] renewal_seconds;
    logic [31:0] rebinding_seconds;
    logic [7:0]  updated_mask;
  } out_item_t;

  typedef struct packed {
    logic      emit;
    out_item_t data;
  } step_res_t;

  function automatic logic [SlotW-1:0] slot_of(input logic [7:0] t);
    case (t)
      OPT_MASK:      slot_of = 3'd0;
      OPT_GATEWAY:   slot_of = 3'd1;
      OPT_BCAST:     slot_of = 3'd2;
      OPT_SERVER:    slot_of = 3'd3;
      OPT_LEASE:     slot_of = 3'd4;
      OPT_RENEWAL:   slot_of = 3'd5;
      OPT_REBINDING: slot_of = 3'd6;
      default:       slot_of = NO_SLOT;
    endcase
  endfunction

  function automatic logic strict_four(input logic [7:0] t);
    strict_four = (t == OPT_MASK) || (t == OPT_GATEWAY) ||
                  (t == OPT_LEASE) || (t == OPT_SERVER);
  endfunction

endpackage

// ----- rtl/core/dhcp_option_parser.sv -----
`timescale 1ns / 1ps
// channel  | ports                          | moves
// input    | in_valid, in_ready, in_data    | one option byte with first/last and offered address
// output   | out_valid, out_ready, out_data | at most one parse result per message
//
// Each byte passes an input register, combinational parse logic, and a result register.
// One byte per cycle sustained while the result is not stalled; a byte passes the input, then the result register.
// Bytes that close no message produce no result transfer.
// Reset (rst_n low, synchronous) empties both registers and ignores bytes until a first byte.
// A stalled result holds the parse step; the input register holds at most one waiting byte.
module dhcp_option_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dop_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dop_pkg::out_item_t out_data
);
  import dop_pkg::*;

  logic      item_valid;
  in_item_t  item;
  logic      room;
  logic      take;
  step_res_t res;

  assign take = item_valid && room;

  dop_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  dop_parse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (take),
    .item    (item),
    .res     (res)
  );

  dop_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && res.emit),
    .load_data (res.data),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/dop_in_stage.sv -----
`timescale 1ns / 1ps
module dop_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dop_pkg::in_item_t in_data,
  input  logic              take,
  output logic              item_valid,
  output dop_pkg::in_item_t item
);
  import dop_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

endmodule

// ----- rtl/core/dop_parse_core.sv -----
`timescale 1ns / 1ps
module dop_parse_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  dop_pkg::in_item_t  item,
  output dop_pkg::step_res_t res
);
  import dop_pkg::*;

  logic [1:0]  phase_r, phase_nxt;
  logic        fin_r, fin_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  left_r, left_nxt;
  logic        len4_r, len4_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] offered_r, offered_nxt;
  logic [31:0] cv_r [NumSlots];
  logic [31:0] cv_nxt [NumSlots];
  logic [7:0]  upd_r, upd_nxt;
  logic        emit;
  logic [1:0]  status;
  logic [7:0]  b;
  logic [SlotW-1:0] slot;

  assign b    = item.option_byte;
  assign slot = slot_of(type_r);

  always_comb begin
    phase_nxt   = phase_r;
    fin_nxt     = fin_r;
    type_nxt    = type_r;
    left_nxt    = left_r;
    len4_nxt    = len4_r;
    shift_nxt   = shift_r;
    offered_nxt = offered_r;
    upd_nxt     = upd_r;
    for (int i = 0; i < NumSlots; i++) begin
      cv_nxt[i] = cv_r[i];
    end
    emit   = 1'b0;
    status = ST_OK;

    if (item.first) begin
      for (int i = 0; i < NumSlots; i++) begin
        cv_nxt[i] = '0;
      end
      upd_nxt     = '0;
      type_nxt    = '0;
      left_nxt    = '0;
      len4_nxt    = 1'b0;
      shift_nxt   = '0;
      phase_nxt   = PH_TYPE;
      offered_nxt = item.your_address;
      fin_nxt     = 1'b0;
    end

    if (!fin_nxt) begin
      case (phase_nxt)
        PH_TYPE: begin
          if (b == OPT_END) begin
            if (offered_nxt != '0) begin
              cv_nxt[SLOT_BCAST] = offered_nxt | 32'h0000_00ff;
              upd_nxt            = upd_nxt | 8'h09;
            end
            emit   = 1'b1;
            status = ST_OK;
          end else if (b != OPT_PAD) begin
            type_nxt  = b;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          len4_nxt  = (b == 8'd4);
          left_nxt  = b;
          shift_nxt = '0;
          if (strict_four(type_nxt) && b != 8'd4) begin
            emit   = 1'b1;
            status = ST_BAD_LEN;
          end else if (type_nxt == OPT_MSG_TYPE && b != 8'd1) begin
            emit   = 1'b1;
            status = ST_BAD_LEN;
          end else begin
            phase_nxt = (b == 8'd0) ? PH_TYPE : PH_VALUE;
          end
        end
        default: begin
          shift_nxt = {shift_nxt[23:0], b};
          left_nxt  = left_nxt - 8'd1;
          if (type_nxt == OPT_MSG_TYPE && b != MSG_OFFER && b != MSG_ACK) begin
            emit   = 1'b1;
            status = ST_BAD_MSG;
          end else if (left_nxt == 8'd0) begin
            phase_nxt = PH_TYPE;
            if (slot != NO_SLOT && len4_nxt) begin
              cv_nxt[slot] = shift_nxt;
              upd_nxt      = upd_nxt | (8'd1 << (slot + 3'd1));
            end
          end
        end
      endcase

      if (!emit && item.last) begin
        emit   = 1'b1;
        status = ST_NO_END;
      end
      if (emit) begin
        fin_nxt   = 1'b1;
        phase_nxt = PH_TYPE;
      end
    end
  end

  always_comb begin
    res.emit                   = emit;
    res.data.status            = status;
    res.data.host_address      = upd_nxt[0] ? offered_nxt : '0;
    res.data.subnet_mask       = cv_nxt[0];
    res.data.router_address    = cv_nxt[1];
    res.data.broadcast_address = cv_nxt[2];
    res.data.server_id         = cv_nxt[3];
    res.data.lease_seconds     = cv_nxt[4];
    res.data.renewal_seconds   = cv_nxt[5];
    res.data.rebinding_seconds = cv_nxt[6];
    res.data.updated_mask      = upd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      fin_r   <= 1'b1;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      type_r    <= type_nxt;
      left_r    <= left_nxt;
      len4_r    <= len4_nxt;
      shift_r   <= shift_nxt;
      offered_r <= offered_nxt;
      upd_r     <= upd_nxt;
      for (int i = 0; i < NumSlots; i++) begin
        cv_r[i] <= cv_nxt[i];
      end
    end
  end

  a_emit_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.emit |=> fin_r && phase_r == PH_TYPE)
    else $error("result transfer did not close the message");

  a_ok_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.emit && res.data.status == ST_OK |-> item.option_byte == OPT_END)
    else $error("ok status without end option");

  a_first_opens: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.first && !res.emit |=> !fin_r)
    else $error("first byte did not open a message");

  a_host_implies_bcast: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.emit && res.data.updated_mask[0] |-> res.data.updated_mask[3])
    else $error("host capture without broadcast");

endmodule

// ----- rtl/core/dop_out_stage.sv -----
`timescale 1ns / 1ps
module dop_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  dop_pkg::out_item_t load_data,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output dop_pkg::out_item_t out_data
);
  import dop_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  assign room      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule
